FILE: hw/rtl/pwad_pkg.sv
// Shared types, constants and helpers for the angle-to-converter-code block.
`timescale 1ns / 1ps

package pwad_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // Calibration points
  localparam int PT_W    = 16;
  localparam int NUM_PTS = 9;

  // Interpolation divider: quotient stays below 1000, so 10 bits
  localparam int QUO_W = 10;
  localparam int NUM_W = PT_W + QUO_W;

  // Result fields
  localparam int SEC_W       = 4;
  localparam int ANG_OUT_W   = 18;
  localparam int DAC_W       = 16;
  localparam int M_TDATA_W   = 40;  // dac_code, angle_hundredths, zero pad
  localparam int M_TUSER_W   = 5;   // section, saturated
  localparam int ANG_LSB     = DAC_W;

  // Section codes
  localparam logic [SEC_W-1:0] SEC_BELOW = 4'd0;
  localparam logic [SEC_W-1:0] SEC_ABOVE = 4'd9;
  localparam logic [SEC_W-1:0] SEC_NONE  = 4'd10;

  // Angle constants, hundredths of a degree
  localparam int ANG_STEP = 1000;
  localparam int ANG_EDGE = 4000;
  localparam int ANG_SAT  = 4500;
  localparam int ANG_SPAN = 9000;

  // Converter mapping: code = (angle + 4500) * 65535 / 9000
  localparam int          DAC_MAX  = 65535;
  localparam int          X_W      = 14;   // angle + 4500, 0..9000
  localparam int          Y_W      = 30;   // x * 65535
  localparam int          RECIP_SH = 44;
  localparam int          RECIP_W  = 31;
  localparam logic [63:0] RECIP_M64 = ((64'd1 << RECIP_SH) + 64'(ANG_SPAN) - 64'd1)
                                      / 64'(ANG_SPAN);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_M64[RECIP_W-1:0];
  localparam logic [DAC_W-1:0]   NONE_CODE = 16'd32767;

  // Register map
  localparam int CFG_AW = 5;
  typedef enum logic [2:0] {
    REG_M40_M30  = 3'd0,
    REG_M20_M10  = 3'd1,
    REG_ZERO_P10 = 3'd2,
    REG_P20_P30  = 3'd3,
    REG_P40      = 3'd4
  } reg_idx_t;

  localparam logic [31:0]     RST_M40_M30  = 32'd939532288;
  localparam logic [31:0]     RST_M20_M10  = 32'd1744850944;
  localparam logic [31:0]     RST_ZERO_P10 = 32'd2550169600;
  localparam logic [31:0]     RST_P20_P30  = 32'd3355488256;
  localparam logic [PT_W-1:0] RST_P40      = 16'd57344;

  // Base angle of interpolated section 1..8: (sec - 5) * 1000
  function automatic logic signed [14:0] base_angle(input logic [SEC_W-1:0] sec);
    int tmp;
    tmp = (int'(sec) - 5) * ANG_STEP;
    return 15'(tmp);
  endfunction

endpackage

FILE: hw/rtl/pwad_front.sv
// Section search, span/offset setup and numerator scaling ahead of the divider row.
`timescale 1ns / 1ps

module pwad_front #(
  parameter int SAMPLE_BITS = pwad_pkg::SAMPLE_BITS_DEF,
  parameter int ANG_W       = 18
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic [pwad_pkg::NUM_PTS-1:0][pwad_pkg::PT_W-1:0]  pts,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [SAMPLE_BITS-1:0]                            in_sample,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [pwad_pkg::PT_W-1:0]                         out_rem,
  output logic [pwad_pkg::QUO_W-1:0]                        out_low,
  output logic [pwad_pkg::PT_W-1:0]                         out_div,
  output logic [pwad_pkg::SEC_W-1:0]                        out_sec,
  output logic signed [ANG_W-1:0]                           out_outer
);

  localparam int CMP_W = (SAMPLE_BITS > pwad_pkg::PT_W) ? SAMPLE_BITS : pwad_pkg::PT_W;

  // stage 1: compare against all points
  logic                         v1, r1;
  logic [SAMPLE_BITS-1:0]       s1_v;
  logic [pwad_pkg::NUM_PTS-1:0] s1_ge;
  logic [pwad_pkg::NUM_PTS-1:0] ge_c;

  // stage 2: section select
  logic                         v2, r2;
  logic [pwad_pkg::SEC_W-1:0]   s2_sec;
  logic [pwad_pkg::PT_W-1:0]    s2_diff;
  logic [pwad_pkg::PT_W-1:0]    s2_span;
  logic signed [ANG_W-1:0]      s2_outer;

  logic [pwad_pkg::SEC_W-1:0]   sec_c;
  logic [pwad_pkg::PT_W-1:0]    lo_c, hi_c;
  logic [CMP_W-1:0]             diff_full;
  logic signed [ANG_W-1:0]      v_s, p_s, off_s, outer_c;

  // stage 3: numerator
  logic                         v3, r3;
  logic [pwad_pkg::NUM_W-1:0]   num_c;

  assign r1 = !v1 || r2;
  assign r2 = !v2 || r3;
  assign r3 = !v3 || out_ready;
  assign in_ready  = r1;
  assign out_valid = v3;

  always_comb begin
    for (int k = 0; k < pwad_pkg::NUM_PTS; k++) begin
      ge_c[k] = CMP_W'(in_sample) >= CMP_W'(pts[k]);
    end
  end

  always_comb begin : sel_blk
    logic found;
    found = 1'b0;
    sec_c = pwad_pkg::SEC_NONE;
    lo_c  = pts[0];
    hi_c  = pts[1];
    if (!s1_ge[0]) begin
      sec_c = pwad_pkg::SEC_BELOW;
    end else begin
      // first section with lo <= v < hi wins
      for (int k = 0; k < pwad_pkg::NUM_PTS - 1; k++) begin
        if (!found && s1_ge[k] && !s1_ge[k+1]) begin
          found = 1'b1;
          sec_c = pwad_pkg::SEC_W'(k + 1);
          lo_c  = pts[k];
          hi_c  = pts[k+1];
        end
      end
      if (!found && s1_ge[pwad_pkg::NUM_PTS-1]) begin
        sec_c = pwad_pkg::SEC_ABOVE;
      end
    end
  end

  assign diff_full = CMP_W'(s1_v) - CMP_W'(lo_c);

  // outside the end points: v - P0 - 4000 below, v - P40 + 4000 above
  always_comb begin
    v_s   = $signed(ANG_W'(s1_v));
    p_s   = $signed(ANG_W'((sec_c == pwad_pkg::SEC_BELOW) ? pts[0]
                                                          : pts[pwad_pkg::NUM_PTS-1]));
    off_s = (sec_c == pwad_pkg::SEC_BELOW) ? ANG_W'(-pwad_pkg::ANG_EDGE)
                                           : ANG_W'(pwad_pkg::ANG_EDGE);
    if (sec_c == pwad_pkg::SEC_BELOW || sec_c == pwad_pkg::SEC_ABOVE) begin
      outer_c = v_s - p_s + off_s;
    end else begin
      outer_c = '0;
    end
  end

  assign num_c = pwad_pkg::NUM_W'(s2_diff) * pwad_pkg::NUM_W'(pwad_pkg::ANG_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1_v  <= in_sample;
      s1_ge <= ge_c;
    end
    if (r2 && v1) begin
      s2_sec   <= sec_c;
      s2_diff  <= diff_full[pwad_pkg::PT_W-1:0];
      s2_span  <= hi_c - lo_c;
      s2_outer <= outer_c;
    end
    if (r3 && v2) begin
      out_rem   <= num_c[pwad_pkg::NUM_W-1:pwad_pkg::QUO_W];
      out_low   <= num_c[pwad_pkg::QUO_W-1:0];
      out_div   <= s2_span;
      out_sec   <= s2_sec;
      out_outer <= s2_outer;
    end
  end

endmodule

FILE: hw/rtl/pwad_div_cell.sv
// One restoring-divide cell: resolves one quotient bit and hands on to the next cell.
`timescale 1ns / 1ps

module pwad_div_cell #(
  parameter int SIDE_W = 22
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pwad_pkg::PT_W-1:0]   in_rem,
  input  logic [pwad_pkg::QUO_W-1:0]  in_low,
  input  logic [pwad_pkg::QUO_W-1:0]  in_quo,
  input  logic [pwad_pkg::PT_W-1:0]   in_div,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pwad_pkg::PT_W-1:0]   out_rem,
  output logic [pwad_pkg::QUO_W-1:0]  out_low,
  output logic [pwad_pkg::QUO_W-1:0]  out_quo,
  output logic [pwad_pkg::PT_W-1:0]   out_div,
  output logic [SIDE_W-1:0]           out_side
);

  logic [pwad_pkg::PT_W:0] trial, diff;
  logic                    take;

  assign in_ready = !out_valid || out_ready;

  // bring down the next dividend bit, subtract if it fits
  assign trial = {in_rem, in_low[pwad_pkg::QUO_W-1]};
  assign take  = trial >= {1'b0, in_div};
  assign diff  = trial - {1'b0, in_div};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem  <= take ? diff[pwad_pkg::PT_W-1:0] : trial[pwad_pkg::PT_W-1:0];
      out_low  <= {in_low[pwad_pkg::QUO_W-2:0], 1'b0};
      out_quo  <= {in_quo[pwad_pkg::QUO_W-2:0], take};
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule

FILE: hw/rtl/pwad_dac_map.sv
// Angle assembly, saturation and angle-to-converter-code scaling.
`timescale 1ns / 1ps

module pwad_dac_map #(
  parameter int ANG_W = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pwad_pkg::QUO_W-1:0]        in_quo,
  input  logic [pwad_pkg::SEC_W-1:0]        in_sec,
  input  logic signed [ANG_W-1:0]           in_outer,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pwad_pkg::DAC_W-1:0]        dac_code,
  output logic [pwad_pkg::ANG_OUT_W-1:0]    angle_hundredths,
  output logic [pwad_pkg::SEC_W-1:0]        section,
  output logic                              saturated
);

  localparam int PROD_W = pwad_pkg::Y_W + pwad_pkg::RECIP_W;
  localparam logic signed [ANG_W-1:0] SAT_HI_S = ANG_W'(pwad_pkg::ANG_SAT);
  localparam logic signed [ANG_W-1:0] SAT_LO_S = -SAT_HI_S;

  logic                         va, ra, vb, rb, vc, rc, rout;
  logic                         interp_c;
  logic signed [ANG_W-1:0]      angle_c, xs_c;
  logic [pwad_pkg::X_W-1:0]     x_c;

  logic signed [ANG_W-1:0]      sa_angle, sb_angle, sc_angle;
  logic [pwad_pkg::SEC_W-1:0]   sa_sec, sb_sec, sc_sec;
  logic                         sb_lo, sb_hi, sc_lo, sc_hi;
  logic [pwad_pkg::Y_W-1:0]     sb_y;
  logic [PROD_W-1:0]            sc_prod;

  assign rout = !out_valid || out_ready;
  assign rc   = !vc || rout;
  assign rb   = !vb || rc;
  assign ra   = !va || rb;
  assign in_ready = ra;

  // interpolated sections 1..8 add the quotient to the section base
  assign interp_c = (in_sec != pwad_pkg::SEC_BELOW) && (in_sec < pwad_pkg::SEC_ABOVE);
  assign angle_c  = interp_c ? (ANG_W'(pwad_pkg::base_angle(in_sec))
                                + $signed(ANG_W'(in_quo)))
                             : in_outer;

  assign xs_c = sa_angle + SAT_HI_S;
  assign x_c  = xs_c[pwad_pkg::X_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ra)   va        <= in_valid;
      if (rb)   vb        <= va;
      if (rc)   vc        <= vb;
      if (rout) out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      sa_angle <= angle_c;
      sa_sec   <= in_sec;
    end
    if (rb && va) begin
      sb_angle <= sa_angle;
      sb_sec   <= sa_sec;
      sb_lo    <= sa_angle < SAT_LO_S;
      sb_hi    <= sa_angle > SAT_HI_S;
      // x * 65535 as shift and subtract
      sb_y     <= (pwad_pkg::Y_W'(x_c) << pwad_pkg::DAC_W) - pwad_pkg::Y_W'(x_c);
    end
    if (rc && vb) begin
      sc_angle <= sb_angle;
      sc_sec   <= sb_sec;
      sc_lo    <= sb_lo;
      sc_hi    <= sb_hi;
      // exact floor(y / 9000) via rounded-up reciprocal
      sc_prod  <= PROD_W'(sb_y) * PROD_W'(pwad_pkg::RECIP_M);
    end
    if (rout && vc) begin
      if (sc_hi) begin
        dac_code <= pwad_pkg::DAC_W'(pwad_pkg::DAC_MAX);
      end else if (sc_lo) begin
        dac_code <= '0;
      end else begin
        dac_code <= sc_prod[pwad_pkg::RECIP_SH +: pwad_pkg::DAC_W];
      end
      angle_hundredths <= sc_angle[pwad_pkg::ANG_OUT_W-1:0];
      section          <= sc_sec;
      saturated        <= sc_lo || sc_hi;
    end
  end

endmodule

FILE: hw/rtl/piecewise_angle_to_dac_code.sv
// Top level: calibrated sample-to-angle conversion driving a 16-bit converter code.
`timescale 1ns / 1ps

//  Channel | Dir | Handshake               | Content
//  --------+-----+-------------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready     | tdata: sample
//  m_*     | out | m_tvalid / m_tready     | tdata: dac_code, angle_hundredths, pad
//          |     |                         | tuser: section, saturated
//  APB     | in  | psel/penable/pwrite     | five calibration registers at 4*i
//
//  Throughput: one sample per cycle while m_tready does not stall the output; 3 front stages,
//  10 divide cells and 4 mapping stages, as the 10-bit quotient is resolved one bit per cell.
//  Reset: rst is synchronous, clears all stage valids and loads the default points.
//  Stalls: every stage has its own valid and accepts when empty or draining, so
//  bubbles close up and input keeps flowing while a result waits on m_tready, until every stage is full.
//  Points are read live; rewrite them only while the pipe is empty.

module piecewise_angle_to_dac_code #(
  parameter int SAMPLE_BITS = pwad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // stream in
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] sample
  // stream out
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [pwad_pkg::M_TDATA_W-1:0]         m_tdata,   // [15:0] dac_code,
                                                            // [33:16] angle_hundredths
  output logic [pwad_pkg::M_TUSER_W-1:0]         m_tuser,   // [3:0] section, [4] saturated
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [pwad_pkg::CFG_AW-1:0]            paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  // signed width holding any angle before it is cut to the 18-bit field
  localparam int ANG_W  = (SAMPLE_BITS + 2 > pwad_pkg::ANG_OUT_W) ? SAMPLE_BITS + 2
                                                                   : pwad_pkg::ANG_OUT_W;
  localparam int SIDE_W = pwad_pkg::SEC_W + ANG_W;
  localparam int NCELL  = pwad_pkg::QUO_W;

  // ---------------- configuration ----------------
  logic [31:0]                 cfg_m40_m30, cfg_m20_m10, cfg_zero_p10, cfg_p20_p30;
  logic [pwad_pkg::PT_W-1:0]   cfg_p40;
  logic                        cfg_wr;
  pwad_pkg::reg_idx_t          cfg_idx;
  logic [pwad_pkg::NUM_PTS-1:0][pwad_pkg::PT_W-1:0] pts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pwad_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_m40_m30  <= pwad_pkg::RST_M40_M30;
      cfg_m20_m10  <= pwad_pkg::RST_M20_M10;
      cfg_zero_p10 <= pwad_pkg::RST_ZERO_P10;
      cfg_p20_p30  <= pwad_pkg::RST_P20_P30;
      cfg_p40      <= pwad_pkg::RST_P40;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pwad_pkg::REG_M40_M30:  cfg_m40_m30  <= pwdata;
        pwad_pkg::REG_M20_M10:  cfg_m20_m10  <= pwdata;
        pwad_pkg::REG_ZERO_P10: cfg_zero_p10 <= pwdata;
        pwad_pkg::REG_P20_P30:  cfg_p20_p30  <= pwdata;
        pwad_pkg::REG_P40:      cfg_p40      <= pwdata[pwad_pkg::PT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pwad_pkg::REG_M40_M30:  prdata = cfg_m40_m30;
      pwad_pkg::REG_M20_M10:  prdata = cfg_m20_m10;
      pwad_pkg::REG_ZERO_P10: prdata = cfg_zero_p10;
      pwad_pkg::REG_P20_P30:  prdata = cfg_p20_p30;
      pwad_pkg::REG_P40:      prdata = {16'd0, cfg_p40};
      default:                prdata = '0;
    endcase
  end

  // breakpoints -40 .. +40 in ascending order
  assign pts[0] = cfg_m40_m30[15:0];
  assign pts[1] = cfg_m40_m30[31:16];
  assign pts[2] = cfg_m20_m10[15:0];
  assign pts[3] = cfg_m20_m10[31:16];
  assign pts[4] = cfg_zero_p10[15:0];
  assign pts[5] = cfg_zero_p10[31:16];
  assign pts[6] = cfg_p20_p30[15:0];
  assign pts[7] = cfg_p20_p30[31:16];
  assign pts[8] = cfg_p40;

  // ---------------- front: section search ----------------
  logic [pwad_pkg::SEC_W-1:0]  f_sec;
  logic signed [ANG_W-1:0]     f_outer;

  // divider row links, index i feeds cell i
  logic [NCELL:0]                            c_valid, c_ready;
  logic [NCELL:0][pwad_pkg::PT_W-1:0]        c_rem, c_div;
  logic [NCELL:0][pwad_pkg::QUO_W-1:0]       c_low, c_quo;
  logic [NCELL:0][SIDE_W-1:0]                c_side;

  pwad_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ANG_W       (ANG_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pts       (pts),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata[SAMPLE_BITS-1:0]),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_rem   (c_rem[0]),
    .out_low   (c_low[0]),
    .out_div   (c_div[0]),
    .out_sec   (f_sec),
    .out_outer (f_outer)
  );

  assign c_quo[0]  = '0;
  assign c_side[0] = {f_sec, f_outer};

  // ---------------- divider row: one quotient bit per cell ----------------
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pwad_div_cell #(
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_rem    (c_rem[i]),
      .in_low    (c_low[i]),
      .in_quo    (c_quo[i]),
      .in_div    (c_div[i]),
      .in_side   (c_side[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_low   (c_low[i+1]),
      .out_quo   (c_quo[i+1]),
      .out_div   (c_div[i+1]),
      .out_side  (c_side[i+1])
    );
  end

  // ---------------- mapping to converter code ----------------
  logic [pwad_pkg::DAC_W-1:0]      o_dac;
  logic [pwad_pkg::ANG_OUT_W-1:0]  o_angle;
  logic [pwad_pkg::SEC_W-1:0]      o_sec;
  logic                            o_sat;

  pwad_dac_map #(
    .ANG_W (ANG_W)
  ) u_map (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (c_valid[NCELL]),
    .in_ready         (c_ready[NCELL]),
    .in_quo           (c_quo[NCELL]),
    .in_sec           (c_side[NCELL][SIDE_W-1 -: pwad_pkg::SEC_W]),
    .in_outer         ($signed(c_side[NCELL][ANG_W-1:0])),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .dac_code         (o_dac),
    .angle_hundredths (o_angle),
    .section          (o_sec),
    .saturated        (o_sat)
  );

  assign m_tdata = {{(pwad_pkg::M_TDATA_W - pwad_pkg::DAC_W - pwad_pkg::ANG_OUT_W){1'b0}},
                    o_angle, o_dac};
  assign m_tuser = {o_sat, o_sec};

endmodule

FILE: hw/rtl/pwad_checker.sv
// Port-level checks on the result stream, bound to the top level.
`timescale 1ns / 1ps

module pwad_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pwad_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [pwad_pkg::M_TUSER_W-1:0]  m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[3:0] <= pwad_pkg::SEC_NONE)
    else $error("section code out of range");

  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> m_tdata[15:0] == '0 || m_tdata[15:0] == '1)
    else $error("saturated result without end code");

  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:0] == pwad_pkg::SEC_NONE
      |-> m_tdata[15:0] == pwad_pkg::NONE_CODE && m_tdata[33:16] == '0)
    else $error("unmatched sample not at mid code");

  // interpolated sections never saturate: their angles stay inside -40..+40 degrees
  a_interp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:0] != pwad_pkg::SEC_BELOW && m_tuser[3:0] < pwad_pkg::SEC_ABOVE
      |-> !m_tuser[4])
    else $error("interpolated section saturated");

endmodule

bind piecewise_angle_to_dac_code pwad_checker u_pwad_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/sv/piecewise_angle_to_dac_code_tb.sv
// Testbench for piecewise_angle_to_dac_code: predicted angles and codes checked per transaction.
`timescale 1ns / 1ps

// Drives samples on the input stream and reprograms the nine calibration points
// over APB between phases. Each accepted sample is run through a local model of
// the section lookup, interpolation and converter mapping. Each output
// transaction is compared field by field against the oldest prediction.
module piecewise_angle_to_dac_code_tb;
  import pwad_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;  // several times the slowest legal run
  localparam int DRAIN_CYCLES = 24;      // extra wait for the pipe to settle after the last result
  localparam int SEGMENTS     = 13;
  localparam int SEG_ITEMS    = 150;

  // One predicted output transaction
  typedef struct packed {
    logic [DAC_W-1:0]     dac;
    logic [ANG_OUT_W-1:0] angle;
    logic [SEC_W-1:0]     section;
    logic                 sat;
  } code_rec_t;

  // Holds a copy of the calibration points and the queue of predicted codes.
  class calib_checker;
    int        pts[NUM_PTS];
    code_rec_t pending_codes[$];
    int        mismatches;

    function new();
      mismatches = 0;
      set_reg(REG_M40_M30, RST_M40_M30);
      set_reg(REG_M20_M10, RST_M20_M10);
      set_reg(REG_ZERO_P10, RST_ZERO_P10);
      set_reg(REG_P20_P30, RST_P20_P30);
      set_reg(REG_P40, {16'd0, RST_P40});
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_M40_M30: begin
          pts[0] = val[15:0];
          pts[1] = val[31:16];
        end
        REG_M20_M10: begin
          pts[2] = val[15:0];
          pts[3] = val[31:16];
        end
        REG_ZERO_P10: begin
          pts[4] = val[15:0];
          pts[5] = val[31:16];
        end
        REG_P20_P30: begin
          pts[6] = val[15:0];
          pts[7] = val[31:16];
        end
        REG_P40: pts[NUM_PTS-1] = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction

    // Sample -> section, angle in hundredths, converter code.
    function code_rec_t convert_sample(logic [15:0] smp);
      code_rec_t r;
      longint    v;
      longint    ang;
      longint    span;
      int        k;
      v         = smp;
      ang       = 0;
      r.section = SEC_NONE;
      r.sat     = 1'b0;
      if (v < pts[0]) begin
        // below -40: one hundredth per count past the end point
        ang       = -ANG_EDGE - (pts[0] - v);
        r.section = SEC_BELOW;
      end else begin
        // first matching section wins
        for (k = 0; k < NUM_PTS - 1; k++) begin
          if (r.section == SEC_NONE && v >= pts[k] && v < pts[k+1]) begin
            span      = pts[k+1] - pts[k];
            ang       = (v - pts[k]) * ANG_STEP / span + longint'(k - 4) * ANG_STEP;
            r.section = SEC_W'(k + 1);
          end
        end
        if (r.section == SEC_NONE && v >= pts[NUM_PTS-1]) begin
          ang       = v - pts[NUM_PTS-1] + ANG_EDGE;
          r.section = SEC_ABOVE;
        end
      end
      if (ang < -ANG_SAT) begin
        r.dac = '0;
        r.sat = 1'b1;
      end else if (ang > ANG_SAT) begin
        r.dac = DAC_W'(DAC_MAX);
        r.sat = 1'b1;
      end else begin
        r.dac = DAC_W'((ang + ANG_SAT) * DAC_MAX / ANG_SPAN);
      end
      r.angle = ang[ANG_OUT_W-1:0];
      return r;
    endfunction

    function void note_sample(logic [15:0] smp);
      pending_codes.push_back(convert_sample(smp));
    endfunction

    function void cmp_field(string name, longint want, longint got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_code(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
      code_rec_t want;
      if (pending_codes.size() == 0) begin
        $error("output transaction with no sample pending: tdata %h tuser %h", tdata, tuser);
        mismatches++;
        return;
      end
      want = pending_codes.pop_front();
      cmp_field("dac_code", want.dac, tdata[DAC_W-1:0]);
      cmp_field("angle_hundredths", $signed(want.angle), $signed(tdata[ANG_LSB +: ANG_OUT_W]));
      cmp_field("section", want.section, tuser[SEC_W-1:0]);
      cmp_field("saturated", want.sat, tuser[SEC_W]);
      cmp_field("tdata_pad", 0, tdata[M_TDATA_W-1:ANG_LSB+ANG_OUT_W]);
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata  = '0;   // [15:0] sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;         // [15:0] dac_code, [33:16] angle_hundredths, pad
  logic [M_TUSER_W-1:0]  m_tuser;         // [3:0] section, [4] saturated
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_AW-1:0]     paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic [31:0]           prdata;
  logic                  pready;

  calib_checker sb;
  int           src_idle_pct  = 18;   // chance per cycle the sender holds off
  int           sink_idle_pct = 84;   // chance per cycle the receiver stalls
  int           cycles        = 0;

  piecewise_angle_to_dac_code DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Monitor: values seen here are the ones settled before the edge, so a
  // transaction counts exactly when the design sees valid and ready high.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata);
      if (m_tvalid && m_tready) sb.check_code(m_tdata, m_tuser);
    end
  end

  // One input transaction, with random hold-off cycles in front of it.
  // valid stays high between back-to-back samples.
  task automatic send_sample(input logic [15:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop the source and wait for every predicted result, then let the pipe settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a readback of the same register.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] readback_want;
    readback_want = (idx == REG_P40) ? {16'd0, val[15:0]} : val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // back-to-back read, psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.cmp_field("prdata", readback_want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  initial begin
    int          seg;
    int          ri;
    int          k;
    int          r;
    int          s;
    int          lo_s;
    int          hi_s;
    int          base;
    int          step;
    int          cal[NUM_PTS];
    int          q[$];
    logic [31:0] wval;

    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset calibration: range ends, both sides of the +-45 degree
    // saturation edges, and every breakpoint with the count just below it.
    send_sample(16'd0);
    send_sample(16'hFFFF);
    send_sample(16'(sb.pts[0] - 501));
    send_sample(16'(sb.pts[0] - 500));
    for (k = 0; k < NUM_PTS; k++) begin
      send_sample(16'(sb.pts[k]));
      send_sample(16'(sb.pts[k] - 1));
    end
    send_sample(16'(sb.pts[NUM_PTS-1] + 500));
    send_sample(16'(sb.pts[NUM_PTS-1] + 501));

    // Random segments, each with its own calibration. Variants rotate:
    // sorted random, evenly spaced (tiny spans too), unsorted, and extremes.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        src_idle_pct  = 18;
        sink_idle_pct = 84;
      end else if (seg < 8) begin
        src_idle_pct  = 84;
        sink_idle_pct = 18;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end

      case (seg % 4)
        0: begin
          q.delete();
          for (k = 0; k < NUM_PTS; k++) q.push_back(int'($urandom_range(65535)));
          q.sort();
          for (k = 0; k < NUM_PTS; k++) cal[k] = q[k];
        end
        1: begin
          base = int'($urandom_range(40000));
          step = int'($urandom_range(4000, 1));
          for (k = 0; k < NUM_PTS; k++) cal[k] = (base + k * step > 65535) ? 65535
                                                                           : base + k * step;
        end
        2: begin
          // non-ascending points: sections may overlap or vanish
          for (k = 0; k < NUM_PTS; k++) cal[k] = int'($urandom_range(65535));
        end
        default: begin
          for (k = 0; k < NUM_PTS; k++) begin
            case ((seg / 4) % 3)
              0:       cal[k] = 0;
              1:       cal[k] = 65535;
              default: cal[k] = (k == NUM_PTS - 1) ? 65535 : k * 8192;
            endcase
          end
        end
      endcase

      // Registers change only with the pipe empty.
      wait_idle();
      for (ri = 0; ri < 5; ri++) begin
        if (ri < 4) wval = {16'(cal[2*ri+1]), 16'(cal[2*ri])};
        else        wval = {16'($urandom), 16'(cal[NUM_PTS-1])};  // upper half is ignored
        write_reg(reg_idx_t'(ri), wval);
      end

      repeat (SEG_ITEMS) begin
        r = int'($urandom_range(99));
        if (r < 10) begin
          s = $urandom_range(1) ? 65535 : 0;
        end else if (r < 45) begin
          // around a breakpoint
          s = sb.pts[$urandom_range(NUM_PTS-1)] + int'($urandom_range(8)) - 4;
        end else if (r < 65) begin
          s = int'($urandom_range(65535));
        end else begin
          // mostly inside the calibrated span, a little past both ends
          lo_s = sb.pts[0] - 600;
          hi_s = sb.pts[NUM_PTS-1] + 600;
          if (lo_s < 0) lo_s = 0;
          if (hi_s > 65535) hi_s = 65535;
          if (lo_s > hi_s) s = int'($urandom_range(65535));
          else             s = int'($urandom_range(hi_s, lo_s));
        end
        if (s < 0) s = 0;
        if (s > 65535) s = 65535;
        send_sample(16'(s));
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pwad_pkg.sv
hw/rtl/pwad_front.sv
hw/rtl/pwad_div_cell.sv
hw/rtl/pwad_dac_map.sv
hw/rtl/piecewise_angle_to_dac_code.sv
hw/rtl/pwad_checker.sv
tb/sv/piecewise_angle_to_dac_code_tb.sv
